// File: design/lfss_pkg.sv
`default_nettype none
package lfss_pkg;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic [1:0] CFG_FOCUS  = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] view_u;
    logic signed [15:0] view_v;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [17:0]        pixel_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       covered;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MUL,
    ST_SPLIT,
    ST_SRD,
    ST_SMUL,
    ST_SSUM,
    ST_SWR,
    ST_RRD,
    ST_RDIV,
    ST_ROUT
  } state_t;

endpackage
`default_nettype wire

// File: design/lfss_ram.sv
`default_nettype none
module lfss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/light_field_shift_and_sum_top.sv
`default_nettype none
// Light-field refocus by shift and sum with bilinear weights.
// Input channel: an item is taken when start is high and busy is low.
//   mode 0 starts a view: shift = focus*(u,v), split into integer shift and
//   8-bit fractions, from which four Q1.16 bilinear weights follow.
//   mode 1 is one RGB sample of the view in raster order; a row store forms
//   2x2 quads, and the weighted quad is added to the accumulator entry.
//   mode 2 reads one output pixel: rounded mean, clamped, and clears it.
// Result channel: out_valid pulses for one cycle in mode 2 only; there is
//   no back-pressure, the receiver must take it.
// Config: cfg_we/cfg_index/cfg_data, written while idle; no read-back.
// Sequencing: mode 0 runs MUL then SPLIT, mode 1 runs read, multiply,
//   sum, write back through one accumulator memory port, mode 2 runs a
//   read state, then per colour a bit-serial divider of 34 steps plus a
//   load step, then the strobe state. Mode 3 and ignored samples go
//   straight back to idle.
// Reset: after rst_n the block sweeps the accumulator and the row store,
//   one entry a cycle, MAX_WIDTH*MAX_HEIGHT entries (262144 by default),
//   with busy high.
module light_field_shift_and_sum_top
  import lfss_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_VIEWS  = 256
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item,
  input  wire logic      cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int CW    = $clog2(MAX_VIEWS + 1);
  localparam int EW    = 3 * 32 + CW;
  localparam int DW    = 13;

  state_t state_r, state_nxt;
  logic signed [15:0] focus_r;
  logic [9:0] width_r, height_r;
  logic [DW-1:0] w_eff, h_eff;
  in_item_t item_r;
  logic signed [31:0] px_r, py_r;
  logic signed [16:0] sx_r, sy_r;
  logic [7:0] fx_r, fy_r;
  logic [XW:0] col_r;
  logic [DW-1:0] row_r;
  logic [23:0] prev_r, cur_r;
  logic [AW:0] clr_r;
  logic [AW-1:0] idx_r;
  logic hit_r;
  logic [16:0] wa_r, wb_r, wc_r, wd_r;
  logic [26:0] pr_r [3][4];
  logic [EW-1:0] ent_r;
  logic [5:0] dcnt_r;
  logic [1:0] ch_r;
  logic [33:0] rem_r;
  logic [33:0] quo_r;
  logic [7:0] res_r [3];

  // effective sizes
  always_comb begin
    w_eff = (width_r < 10'd2) ? DW'(2) : (DW'(width_r) > DW'(MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(width_r));
    h_eff = (height_r < 10'd2) ? DW'(2) : (DW'(height_r) > DW'(MAX_HEIGHT) ? DW'(MAX_HEIGHT) : DW'(height_r));
  end

  // memories
  logic acc_we;
  logic [AW-1:0] acc_wa, acc_ra;
  logic [EW-1:0] acc_wd, acc_rd;
  logic rs_we;
  logic [XW-1:0] rs_wa, rs_ra;
  logic [23:0] rs_wd, rs_rd;
  logic [23:0] rs2_rd;

  lfss_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_acc (
    .clk, .we(acc_we), .waddr(acc_wa), .wdata(acc_wd), .raddr(acc_ra), .rdata(acc_rd));
  lfss_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_row_a (
    .clk, .we(rs_we), .waddr(rs_wa), .wdata(rs_wd), .raddr(rs_ra), .rdata(rs_rd));
  lfss_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_row_b (
    .clk, .we(rs_we), .waddr(rs_wa), .wdata(rs_wd),
    .raddr(XW'(col_r - 1'b1)), .rdata(rs2_rd));

  // quad placement
  logic signed [DW+2:0] ox, oy;
  logic in_img, quad_ok;
  logic [2*DW-1:0] lin;
  always_comb begin
    ox = $signed({3'b0, DW'(col_r)}) - 1 - (DW+3)'(sx_r);
    oy = $signed({3'b0, row_r}) - 1 - (DW+3)'(sy_r);
    in_img = (ox >= 0) && (ox < $signed({3'b0, w_eff})) &&
             (oy >= 0) && (oy < $signed({3'b0, h_eff}));
    quad_ok = (col_r != '0) && (row_r != '0) && in_img;
    lin = DW'(oy) * w_eff + (2*DW)'(DW'(ox));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == (AW+1)'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (start) begin
        unique case (mode_t'(in_item.mode))
          MODE_START:  state_nxt = ST_MUL;
          MODE_SAMPLE: state_nxt = (row_r >= h_eff) ? ST_IDLE : ST_SRD;
          MODE_READ:   state_nxt = ST_RRD;
          MODE_NONE:   state_nxt = ST_IDLE;
        endcase
      end
      ST_MUL:   state_nxt = ST_SPLIT;
      ST_SPLIT: state_nxt = ST_IDLE;
      ST_SRD:   state_nxt = ST_SMUL;
      ST_SMUL:  state_nxt = ST_SSUM;
      ST_SSUM:  state_nxt = ST_SWR;
      ST_SWR:   state_nxt = ST_IDLE;
      ST_RRD:   state_nxt = ST_RDIV;
      ST_RDIV:  if (dcnt_r == 6'd34 && ch_r == 2'd2) state_nxt = ST_ROUT;
      ST_ROUT:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  logic [EW-1:0] upd;
  logic [34:0] s3 [3];
  logic [31:0] snew [3];
  logic [CW-1:0] cnt_rd;
  always_comb begin
    cnt_rd = ent_r[CW-1:0];
    for (int c = 0; c < 3; c++) begin
      s3[c] = 35'(pr_r[c][0]) + 35'(pr_r[c][1]) + 35'(pr_r[c][2]) + 35'(pr_r[c][3])
            + 35'(ent_r[EW-1-32*c -: 32]);
      snew[c] = (s3[c] > 35'hFFFF_FFFF) ? 32'hFFFF_FFFF : s3[c][31:0];
    end
    upd = {snew[0], snew[1], snew[2], CW'(cnt_rd + 1'b1)};
  end

  always_comb begin
    busy = (state_r != ST_IDLE);
    out_valid = (state_r == ST_ROUT);
    out_item.red_out = res_r[0];
    out_item.green_out = res_r[1];
    out_item.blue_out = res_r[2];
    out_item.covered = (ent_r[CW-1:0] != '0) && hit_r;
    acc_ra = (state_r == ST_IDLE) ? AW'(lin) : idx_r;
    if (state_r == ST_IDLE && mode_t'(in_item.mode) == MODE_READ)
      acc_ra = AW'(in_item.pixel_index);
    acc_we = 1'b0;
    acc_wa = idx_r;
    acc_wd = '0;
    unique case (state_r)
      ST_CLEAR: begin acc_we = 1'b1; acc_wa = clr_r[AW-1:0]; end
      ST_SWR: begin
        acc_we = hit_r && (cnt_rd < CW'(MAX_VIEWS));
        acc_wd = upd;
      end
      ST_ROUT: acc_we = hit_r;
      default: ;
    endcase
    // row store is zeroed during the reset sweep as well
    rs_ra = col_r[XW-1:0];
    rs_we = (state_r == ST_SWR) || (state_r == ST_CLEAR);
    rs_wa = (state_r == ST_CLEAR) ? clr_r[XW-1:0] : col_r[XW-1:0];
    rs_wd = (state_r == ST_CLEAR) ? 24'd0 : cur_r;
  end

  // datapath registers
  logic [33:0] trial;
  logic [33:0] divisor;
  always_comb begin
    divisor = {1'b0, 17'(cnt_rd), 16'd0};
    trial = {rem_r[32:0], quo_r[33]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      focus_r <= '0;
      width_r <= 10'd512;
      height_r <= 10'd512;
      sx_r <= '0; sy_r <= '0; fx_r <= '0; fy_r <= '0;
      col_r <= '0; row_r <= '0; prev_r <= '0;
      hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_we) begin
        priority case (cfg_index)
          CFG_FOCUS:  focus_r <= cfg_data;
          CFG_WIDTH:  width_r <= cfg_data[9:0];
          CFG_HEIGHT: height_r <= cfg_data[9:0];
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: if (start) begin
          item_r <= in_item;
          idx_r <= acc_ra;
          hit_r <= (mode_t'(in_item.mode) == MODE_READ) ?
                   ((2*DW)'(in_item.pixel_index) < (2*DW)'(w_eff * h_eff)) : quad_ok;
          cur_r <= {in_item.red_in, in_item.green_in, in_item.blue_in};
        end
        ST_MUL: begin
          px_r <= focus_r * item_r.view_u;
          py_r <= focus_r * item_r.view_v;
        end
        ST_SPLIT: begin
          sx_r <= 17'(px_r >>> 16); fx_r <= px_r[15:8];
          sy_r <= 17'(py_r >>> 16); fy_r <= py_r[15:8];
          col_r <= '0; row_r <= '0; prev_r <= '0;
        end
        ST_SRD: begin
          wa_r <= (17'd256 - fx_r) * (17'd256 - fy_r);
          wb_r <= 17'(fx_r) * (17'd256 - fy_r);
          wc_r <= (17'd256 - fx_r) * 17'(fy_r);
          wd_r <= 17'(fx_r) * 17'(fy_r);
        end
        ST_SMUL: begin
          ent_r <= acc_rd;
          for (int c = 0; c < 3; c++) begin
            pr_r[c][0] <= wa_r * 27'(rs2_rd[23-8*c -: 8]);
            pr_r[c][1] <= wb_r * 27'(rs_rd[23-8*c -: 8]);
            pr_r[c][2] <= wc_r * 27'(prev_r[23-8*c -: 8]);
            pr_r[c][3] <= wd_r * 27'(cur_r[23-8*c -: 8]);
          end
        end
        ST_SWR: begin
          prev_r <= cur_r;
          if (DW'(col_r) + 1'b1 >= w_eff) begin
            col_r <= '0; row_r <= row_r + 1'b1;
          end else col_r <= col_r + 1'b1;
        end
        ST_RRD: begin
          ent_r <= acc_rd;
          ch_r <= '0; dcnt_r <= '0;
          rem_r <= '0;
          quo_r <= 34'(acc_rd[EW-1 -: 32]) + {1'b0, 17'(acc_rd[CW-1:0]), 16'd0} / 2;
        end
        ST_RDIV: begin
          if (dcnt_r == 6'd34) begin
            res_r[ch_r] <= (!hit_r || cnt_rd == '0) ? 8'd0 :
                           (quo_r > 34'd255 ? 8'd255 : quo_r[7:0]);
            ch_r <= ch_r + 1'b1; dcnt_r <= '0; rem_r <= '0;
            quo_r <= 34'(ent_r[EW-1-32*(ch_r+1) -: 32]) + (divisor >> 1);
          end else begin
            dcnt_r <= dcnt_r + 1'b1;
            if (trial >= divisor) begin
              rem_r <= trial - divisor; quo_r <= {quo_r[32:0], 1'b1};
            end else begin
              rem_r <= trial; quo_r <= {quo_r[32:0], 1'b0};
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
// Testbench for the light-field refocus block.
// Items go in on the command port (start/busy), results come back as one-cycle
// strobes. A scoreboard keeps its own copy of the view state and of the
// accumulator, works out each expected pixel read and checks the strobes in
// order. Images are mostly small so that whole views fit and every pixel is read.

module tb;
  import lfss_pkg::*;

  class refocus_scoreboard;
    // register copies
    logic signed [15:0] focus_q88;
    logic [9:0]         width_reg;
    logic [9:0]         height_reg;
    // view state
    int                 shift_x, shift_y, frac_x, frac_y;
    int                 col_pos, row_pos;
    logic [23:0]        prev_px;
    logic [23:0]        row_buf [512];
    // sparse accumulator: absent entries are zero
    longint             acc_red [int];
    longint             acc_green [int];
    longint             acc_blue [int];
    int                 view_count [int];
    out_item_t          pixel_q [$];
    int                 errors, reads, covered_reads;

    function new();
      focus_q88  = '0;
      width_reg  = 10'd512;
      height_reg = 10'd512;
      shift_x = 0; shift_y = 0; frac_x = 0; frac_y = 0;
      col_pos = 0; row_pos = 0;
      prev_px = '0;
      foreach (row_buf[i]) row_buf[i] = '0;
      errors = 0; reads = 0; covered_reads = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_FOCUS:  focus_q88  = data;
        CFG_WIDTH:  width_reg  = data[9:0];
        CFG_HEIGHT: height_reg = data[9:0];
        default: ;
      endcase
    endfunction

    function int eff_dim(logic [9:0] v);
      if (v < 2) return 2;
      if (v > 512) return 512;
      return int'(v);
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    // floor of the Q16.16 product, then the next 8 bits
    function void split_prod(longint p, output int sh, output int fr);
      sh = int'(p >>> 16);
      fr = int'((p >>> 8) & 64'hFF);
    endfunction

    function longint sat32(longint a, longint b);
      longint s;
      s = a + b;
      return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
    endfunction

    function logic [7:0] pix_mean(longint s, int cnt);
      longint q;
      q = (s + longint'(cnt) * 32768) / (longint'(cnt) * 65536);
      return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function longint quad_sum(logic [23:0] tl, tr, bl, br, int lsb);
      longint a, b, c, d;
      a = longint'(256 - frac_x) * (256 - frac_y);
      b = longint'(frac_x) * (256 - frac_y);
      c = longint'(256 - frac_x) * frac_y;
      d = longint'(frac_x) * frac_y;
      return a * ((tl >> lsb) & 8'hFF) + b * ((tr >> lsb) & 8'hFF) +
             c * ((bl >> lsb) & 8'hFF) + d * ((br >> lsb) & 8'hFF);
    endfunction

    // accepted input item
    function void note_item(in_item_t it);
      int w, h, ox, oy, idx;
      logic [23:0] cur;
      out_item_t px;
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      case (mode_t'(it.mode))
        MODE_START: begin
          split_prod(longint'(focus_q88) * longint'(it.view_u), shift_x, frac_x);
          split_prod(longint'(focus_q88) * longint'(it.view_v), shift_y, frac_y);
          col_pos = 0; row_pos = 0; prev_px = '0;
        end
        MODE_SAMPLE: begin
          if (row_pos < h) begin
            cur = {it.red_in, it.green_in, it.blue_in};
            if (col_pos >= 1 && row_pos >= 1) begin
              ox = col_pos - 1 - shift_x;
              oy = row_pos - 1 - shift_y;
              if (ox >= 0 && ox < w && oy >= 0 && oy < h) begin
                idx = oy * w + ox;
                if (!view_count.exists(idx)) begin
                  view_count[idx] = 0; acc_red[idx] = 0; acc_green[idx] = 0; acc_blue[idx] = 0;
                end
                if (view_count[idx] < 256) begin
                  acc_red[idx] = sat32(acc_red[idx],
                    quad_sum(row_buf[col_pos-1], row_buf[col_pos], prev_px, cur, 16));
                  acc_green[idx] = sat32(acc_green[idx],
                    quad_sum(row_buf[col_pos-1], row_buf[col_pos], prev_px, cur, 8));
                  acc_blue[idx] = sat32(acc_blue[idx],
                    quad_sum(row_buf[col_pos-1], row_buf[col_pos], prev_px, cur, 0));
                  view_count[idx]++;
                end
              end
            end
            row_buf[col_pos] = cur;
            prev_px = cur;
            if (col_pos + 1 >= w) begin
              col_pos = 0; row_pos++;
            end else begin
              col_pos++;
            end
          end
        end
        MODE_READ: begin
          idx = int'(it.pixel_index);
          px = '0;
          if (idx < w * h && view_count.exists(idx)) begin
            if (view_count[idx] != 0) begin
              px.red_out   = pix_mean(acc_red[idx], view_count[idx]);
              px.green_out = pix_mean(acc_green[idx], view_count[idx]);
              px.blue_out  = pix_mean(acc_blue[idx], view_count[idx]);
              px.covered   = 1'b1;
            end
            view_count.delete(idx); acc_red.delete(idx);
            acc_green.delete(idx); acc_blue.delete(idx);
          end
          pixel_q = {pixel_q, px};
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_pixel(out_item_t got);
      out_item_t want;
      if (pixel_q.size() == 0) begin
        report($sformatf("unexpected pixel %h", got));
        return;
      end
      want = pixel_q.pop_front();
      reads++;
      if (want.covered) covered_reads++;
      if (got.red_out !== want.red_out)
        report($sformatf("red got %0d want %0d", got.red_out, want.red_out));
      if (got.green_out !== want.green_out)
        report($sformatf("green got %0d want %0d", got.green_out, want.green_out));
      if (got.blue_out !== want.blue_out)
        report($sformatf("blue got %0d want %0d", got.blue_out, want.blue_out));
      if (got.covered !== want.covered)
        report($sformatf("covered got %0d want %0d", got.covered, want.covered));
    endtask
  endclass

  localparam longint CYCLE_LIMIT = 3_000_000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  refocus_scoreboard sb;
  longint cycles = 0;
  int     items_sent;
  int     views_sent;
  bit     no_gaps;      // stretches with back-to-back items

  light_field_shift_and_sum_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // watchdog; the reset sweep alone clears 262144 accumulator entries
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // results cannot be held off: check every strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_pixel(out_item);
  end

  // One item: optional gap with start low, then hold until busy is low at an edge.
  task send_item(in_item_t it);
    int gap;
    gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_item(it);
    items_sent++;
  endtask

  // Random filler in every field, mode set afterwards
  function in_item_t noise_item(mode_t m);
    in_item_t it;
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    it = bits[$bits(in_item_t)-1:0];
    it.mode = m;
    return it;
  endfunction

  task start_view(logic signed [15:0] u, logic signed [15:0] v);
    in_item_t it;
    it = noise_item(MODE_START);
    it.view_u = u;
    it.view_v = v;
    send_item(it);
    views_sent++;
  endtask

  task send_samples(int n);
    in_item_t it;
    repeat (n) begin
      it = noise_item(MODE_SAMPLE);
      // push some samples to the colour extremes
      case ($urandom_range(0, 7))
        0: {it.red_in, it.green_in, it.blue_in} = '0;
        1: {it.red_in, it.green_in, it.blue_in} = '1;
        default: ;
      endcase
      send_item(it);
    end
  endtask

  task read_pixel(logic [17:0] idx);
    in_item_t it;
    it = noise_item(MODE_READ);
    it.pixel_index = idx;
    send_item(it);
  endtask

  // Wait until every result is in and the block has gone quiet.
  task drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task set_image(logic [15:0] f, logic [15:0] w, logic [15:0] h);
    drain();
    write_reg(CFG_FOCUS, f);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  // Read back every pixel plus a couple beyond the image
  task read_image();
    int n;
    n = sb.eff_dim(sb.width_reg) * sb.eff_dim(sb.height_reg);
    for (int i = 0; i < n; i++) read_pixel(i[17:0]);
    read_pixel(n[17:0]);
    read_pixel(18'($urandom_range(n, 262143)));
  endtask

  initial begin
    int               w, h, nviews, pix;
    logic [15:0]      f;
    logic signed [15:0] u, v;
    sb         = new();
    cycles     = 0;
    items_sent = 0;
    views_sent = 0;
    no_gaps    = 1'b0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_FOCUS;
    cfg_data   = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // default config: unity weights, full 512x512 image
    read_pixel(18'd0);                     // never covered
    read_pixel(18'd262143);                // last pixel, still in range
    send_item(noise_item(MODE_NONE));      // mode 3 is dropped
    start_view(16'sh8000, 16'sh7FFF);
    send_samples(4);                       // first row only fills the row store
    // extreme focus: shifts push every quad off the image
    set_image(16'h7FFF, 16'd3, 16'd3);
    start_view(16'sh7FFF, 16'sh8000);
    send_samples(9);
    set_image(16'h8000, 16'd3, 16'd3);
    start_view(16'sh8000, 16'sh8000);
    send_samples(9);
    // 1.5 x 1.0 and 1.5 x -1.0: shifts 1 and -2, each with a half-pixel fraction
    set_image(16'h0180, 16'd3, 16'd3);
    start_view(16'sh0100, -16'sh0100);
    send_samples(11);                      // two past the last row are ignored
    read_image();
    // width below the minimum is taken as 2; height above the maximum as 512
    set_image(16'h0000, 16'd1, 16'd1023);
    start_view(16'sh0000, 16'sh0000);
    send_samples(6);
    // width change in the middle of a view
    set_image(16'h0000, 16'd4, 16'd4);
    start_view(16'sh0000, 16'sh0000);
    send_samples(6);
    drain();
    write_reg(CFG_WIDTH, 16'd2);
    send_samples(10);
    read_image();
    drain();
    write_reg(CFG_WIDTH, 16'd4);
    read_image();

    // --- coverage saturation: more than 256 views on one pixel ---
    set_image(16'h0000, 16'd2, 16'd2);
    no_gaps = 1'b1;
    for (int i = 0; i < 260; i++) begin
      start_view(16'($urandom), 16'($urandom));
      send_samples(4);
    end
    no_gaps = 1'b0;
    read_image();

    // --- random part: well-formed views on small images, then read back ---
    while (items_sent < 1900) begin
      case ($urandom_range(0, 5))
        0:       f = 16'($urandom);                      // full range, shifts mostly off
        1:       f = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        default: f = 16'($urandom_range(0, 1023) - 512); // small shifts, any fraction
      endcase
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 1);
        1:       w = $urandom_range(0, 1) ? 512 : $urandom_range(513, 1023);
        default: w = $urandom_range(2, 8);
      endcase
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(2, 8);
      set_image(f, w[15:0], h[15:0]);
      no_gaps = ($urandom_range(0, 3) == 0);
      pix = sb.eff_dim(sb.width_reg) * sb.eff_dim(sb.height_reg);
      if (pix > 64) pix = 3 * sb.eff_dim(sb.width_reg) > 80 ? 80 : 3 * sb.eff_dim(sb.width_reg);
      nviews = $urandom_range(1, 4);
      for (int k = 0; k < nviews; k++) begin
        u = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
        v = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
        start_view(u, v);
        case ($urandom_range(0, 7))
          0:       send_samples($urandom_range(0, pix));          // cut short
          1:       send_samples(pix + $urandom_range(1, 5));      // overrun
          default: send_samples(pix);
        endcase
        if ($urandom_range(0, 7) == 0) send_item(noise_item(MODE_NONE));
      end
      // at times let everything come back before reading
      if ($urandom_range(0, 3) == 0) drain();
      if (sb.eff_dim(sb.width_reg) * sb.eff_dim(sb.height_reg) <= 64) read_image();
      else for (int k = 0; k < 8; k++) read_pixel(18'($urandom_range(0, 262143)));
      read_pixel(18'($urandom));             // any index, every bit
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d items over %0d views; %0d pixel reads, %0d of them covered.",
             items_sent, views_sent, sb.reads, sb.covered_reads);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: light_field_shift_and_sum_top.f
design/lfss_pkg.sv
design/lfss_ram.sv
design/light_field_shift_and_sum_top.sv
dv/tb.sv
